@@ rtl/sgef_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgef_pkg;

	// Width of a stride, an extent and the total element count.
	localparam int STRIDE_BITS = 40;

	// Width of the dimension number in a result.
	localparam int DIM_BITS = 3;

	// One input transaction: a stride, and on the innermost dimension the total count.
	typedef struct packed {
		logic [STRIDE_BITS-1:0] stride;
		logic [STRIDE_BITS-1:0] elem_total;
		logic                   last_dim;
	} in_t;

	// One result transaction per dimension, outermost first.
	typedef struct packed {
		logic [DIM_BITS-1:0]    dim_index;
		logic [STRIDE_BITS-1:0] extent;
		logic [STRIDE_BITS-1:0] reduced_stride;
		logic                   last;
	} out_t;

endpackage

`default_nettype wire

@@ rtl/sgef_gcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary GCD, one shift or one subtraction per cycle.
module sgef_gcd import sgef_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [STRIDE_BITS-1:0] a,
	input  logic [STRIDE_BITS-1:0] b,
	output logic                   done,
	output logic [STRIDE_BITS-1:0] result
);

	localparam int KW = $clog2(STRIDE_BITS + 1);

	typedef enum logic [1:0] {
		G_IDLE,
		G_TWOS,
		G_RED,
		G_FIX
	} state_t;

	state_t                 state_q;
	logic [STRIDE_BITS-1:0] a_q;
	logic [STRIDE_BITS-1:0] b_q;
	logic [STRIDE_BITS-1:0] res_q;
	logic [KW-1:0]          k_q;
	logic                   done_q;

	// Common factors of two are stripped first, then odd parts are reduced,
	// and the factors of two are shifted back in at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			res_q   <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == G_FIX) && (k_q == '0);
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						k_q     <= '0;
						state_q <= G_TWOS;
					end
				end
				G_TWOS: begin
					if (a_q == '0 || b_q == '0) begin
						res_q   <= a_q | b_q;
						state_q <= G_FIX;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + KW'(1);
					end else begin
						state_q <= G_RED;
					end
				end
				G_RED: begin
					if (a_q == '0 || b_q == '0) begin
						res_q   <= a_q | b_q;
						state_q <= G_FIX;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q >= b_q) begin
						a_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
				G_FIX: begin
					if (k_q != '0) begin
						res_q <= res_q << 1;
						k_q   <= k_q - KW'(1);
					end else begin
						state_q <= G_IDLE;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

@@ rtl/sgef_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sgef_div import sgef_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [STRIDE_BITS-1:0] dividend,
	input  logic [STRIDE_BITS-1:0] divisor,
	output logic                   done,
	output logic [STRIDE_BITS-1:0] quotient
);

	localparam int NW = $clog2(STRIDE_BITS);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} state_t;

	state_t                 state_q;
	logic [STRIDE_BITS-1:0] rem_q;
	logic [STRIDE_BITS-1:0] quo_q;
	logic [STRIDE_BITS-1:0] dsr_q;
	logic [NW-1:0]          cnt_q;
	logic                   done_q;

	logic [STRIDE_BITS:0]   trial;
	logic [STRIDE_BITS:0]   diff;
	logic                   fits;

	// The next dividend bit moves into the partial remainder each cycle.
	assign trial = {rem_q, quo_q[STRIDE_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			rem_q   <= '0;
			quo_q   <= '0;
			dsr_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == D_RUN) && (cnt_q == '0);
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						rem_q   <= '0;
						quo_q   <= dividend;
						dsr_q   <= divisor;
						cnt_q   <= NW'(STRIDE_BITS - 1);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? diff[STRIDE_BITS-1:0] : trial[STRIDE_BITS-1:0];
					quo_q <= {quo_q[STRIDE_BITS-2:0], fits};
					if (cnt_q == '0) begin
						state_q <= D_IDLE;
					end else begin
						cnt_q <= cnt_q - NW'(1);
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/stride_gcd_extent_factorizer.sv @@
// Stride GCD extent factorizer.
// Input channel (in_valid, in_ready, in_data): one transaction per dimension
// stride, outermost first. The transaction with last_dim set also carries the
// total element count and starts the factorization. Strides beyond MAX_RANK
// are dropped. Transactions without last_dim are taken back to back.
// After the marked transaction, each step u from the second-innermost dimension
// outward runs one GCD per outer stride in a binary GCD unit and then, unless
// that GCD is zero, one division per stride from u outward in a restoring
// divider. Strides with small odd parts finish their GCDs sooner. The two
// serial units run one at a time. Input is not taken while the steps run.
// Output channel (out_valid, out_ready, out_data): R result transactions,
// one per cycle while out_ready is high, the last one flagged. A stalled
// receiver holds the result register and pauses the block; the next run's
// strides are accepted while the final result still waits.
// Reset clears the load count and all control; no output is pending.
`timescale 1ns / 1ps
`default_nettype none

module stride_gcd_extent_factorizer import sgef_pkg::*; #(
	parameter int MAX_RANK = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int CW = $clog2(MAX_RANK + 1);

	typedef enum logic [2:0] {
		S_LOAD,
		S_GINIT,
		S_GSEL,
		S_GWAIT,
		S_DSEL,
		S_DWAIT,
		S_STEP,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          rank_q;
	logic [IW-1:0]          u_q;
	logic [IW-1:0]          v_q;
	logic [STRIDE_BITS-1:0] g_q;
	logic [STRIDE_BITS-1:0] total_q;
	logic                   gcd_start_q;
	logic                   div_start_q;
	logic                   out_valid_q;
	out_t                   out_data_q;

	logic [STRIDE_BITS-1:0] stride_q [MAX_RANK];
	logic [STRIDE_BITS-1:0] extent_q [MAX_RANK];

	logic                   in_accept;
	logic                   full;
	logic [CW-1:0]          cnt_next;
	logic [STRIDE_BITS-1:0] stride_rd;
	logic                   out_free;
	logic                   is_last;
	logic                   gcd_done;
	logic [STRIDE_BITS-1:0] gcd_res;
	logic                   div_done;
	logic [STRIDE_BITS-1:0] div_quot;

	assign in_ready  = (state_q == S_LOAD);
	assign in_accept = in_valid && in_ready;
	assign full      = (cnt_q == CW'(MAX_RANK));
	assign cnt_next  = full ? cnt_q : cnt_q + CW'(1);
	assign stride_rd = stride_q[v_q];
	assign out_free  = !out_valid_q || out_ready;
	assign is_last   = ((CW'(v_q) + CW'(1)) == rank_q);

	// Shared arithmetic units.
	sgef_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start_q),
		.a      (g_q),
		.b      (stride_rd),
		.done   (gcd_done),
		.result (gcd_res)
	);

	sgef_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (stride_rd),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Stride and extent stores.
	always_ff @(posedge clk) begin
		if (in_accept && !full) begin
			stride_q[cnt_q[IW-1:0]] <= in_data.stride;
		end
		if (state_q == S_DWAIT && div_done) begin
			stride_q[v_q] <= div_quot;
		end
		if (state_q == S_STEP) begin
			extent_q[u_q + IW'(1)] <= g_q;
		end
	end

	// Sequencer: load strides, run the GCD and division steps, emit results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			rank_q      <= '0;
			u_q         <= '0;
			v_q         <= '0;
			g_q         <= '0;
			total_q     <= '0;
			gcd_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// The result register fills from the emit state and empties when taken.
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_accept) begin
						cnt_q <= cnt_next;
						if (in_data.last_dim) begin
							total_q <= in_data.elem_total;
							rank_q  <= cnt_next;
							if (cnt_next == CW'(1)) begin
								v_q     <= '0;
								state_q <= S_EMIT;
							end else begin
								u_q     <= IW'(cnt_next - CW'(2));
								v_q     <= IW'(cnt_next - CW'(2));
								state_q <= S_GINIT;
							end
						end
					end
				end
				S_GINIT: begin
					g_q     <= stride_rd;
					state_q <= S_GSEL;
				end
				S_GSEL: begin
					if (v_q == '0) begin
						v_q     <= u_q;
						state_q <= (g_q != '0) ? S_DSEL : S_STEP;
					end else begin
						v_q         <= v_q - IW'(1);
						gcd_start_q <= 1'b1;
						state_q     <= S_GWAIT;
					end
				end
				S_GWAIT: begin
					gcd_start_q <= 1'b0;
					if (gcd_done) begin
						g_q     <= gcd_res;
						state_q <= S_GSEL;
					end
				end
				S_DSEL: begin
					div_start_q <= 1'b1;
					state_q     <= S_DWAIT;
				end
				S_DWAIT: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						if (v_q == '0) begin
							state_q <= S_STEP;
						end else begin
							v_q     <= v_q - IW'(1);
							state_q <= S_DSEL;
						end
					end
				end
				S_STEP: begin
					if (u_q == '0) begin
						v_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						u_q     <= u_q - IW'(1);
						v_q     <= u_q - IW'(1);
						state_q <= S_GINIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_data_q.dim_index      <= DIM_BITS'(v_q);
						out_data_q.extent         <= (v_q == '0) ? total_q : extent_q[v_q];
						out_data_q.reduced_stride <= stride_q[v_q];
						out_data_q.last           <= is_last;
						if (is_last) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							v_q <= v_q + IW'(1);
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The load count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RANK))
		else $error("load count exceeds store depth");

	// The two arithmetic units never finish in the same cycle.
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(gcd_done && div_done))
		else $error("GCD and divider finished together");

	// A GCD result only arrives while the sequencer waits for it.
	a_gcd_wait: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_done |-> state_q == S_GWAIT)
		else $error("GCD result outside its wait state");

	// A quotient only arrives while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DWAIT)
		else $error("quotient outside its wait state");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb import sgef_pkg::*; ();

	localparam int NUM_DIMS = 8;
	localparam int MAX_VIEW = 12;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int MAX_REPORTS = 30;
	localparam int LOAD_TARGET = 460;

	typedef logic [STRIDE_BITS-1:0] count_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Predictor state: strides held for the current view and the results still owed.
	count_t held_stride [NUM_DIMS];
	int     held_count = 0;
	out_t   expected_results [$];
	out_t   next_result;

	// Stimulus state.
	count_t view_stride [MAX_VIEW];
	int     items_loaded = 0;
	int     burst_left = 0;
	int     mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Receiver stall pattern; hold_left forces a long hold-off when set.
	int hold_left = 0;
	int ready_pct = 100;
	int pattern_left = 0;

	stride_gcd_extent_factorizer #(.MAX_RANK(NUM_DIMS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #2 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("stride_gcd_extent_factorizer verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	function automatic count_t gcd_of(input count_t a, input count_t b);
		count_t r;
		while (b != '0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// Store the stride of an accepted transaction; on the innermost dimension,
	// factor the held strides and queue one expected result per dimension.
	task automatic predict_factorization(input in_t item);
		count_t extent [NUM_DIMS];
		count_t g;
		out_t   res;
		int     rank;
		if (held_count < NUM_DIMS) begin
			held_stride[held_count] = item.stride;
			held_count++;
		end
		if (item.last_dim) begin
			rank = held_count;
			extent[0] = item.elem_total;
			// Peel the common factor of each dimension and everything outside it.
			for (int u = rank - 2; u >= 0; u--) begin
				g = held_stride[u];
				for (int v = u - 1; v >= 0; v--)
					g = gcd_of(g, held_stride[v]);
				if (g != '0) begin
					for (int v = u; v >= 0; v--)
						held_stride[v] = held_stride[v] / g;
				end
				extent[u + 1] = g;
			end
			for (int u = 0; u < rank; u++) begin
				res.dim_index = DIM_BITS'(u);
				res.extent = extent[u];
				res.reduced_stride = held_stride[u];
				res.last = (u == rank - 1);
				expected_results.push_back(res);
			end
			held_count = 0;
		end
	endtask

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, dim_index", 64'(out_data.dim_index),
					64'(0));
			end else begin
				next_result = expected_results.pop_front();
				if (out_data.dim_index !== next_result.dim_index)
					report_mismatch("dim_index", 64'(out_data.dim_index),
						64'(next_result.dim_index));
				if (out_data.extent !== next_result.extent)
					report_mismatch("extent", 64'(out_data.extent), 64'(next_result.extent));
				if (out_data.reduced_stride !== next_result.reduced_stride)
					report_mismatch("reduced_stride", 64'(out_data.reduced_stride),
						64'(next_result.reduced_stride));
				if (out_data.last !== next_result.last)
					report_mismatch("last", 64'(out_data.last), 64'(next_result.last));
			end
		end
	end

	// Receiver: changes its readiness pattern now and then, or holds off entirely.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			if (pattern_left == 0) begin
				case ($urandom_range(0, 4))
					0, 1: ready_pct <= 100;
					2: ready_pct <= 85;
					3: ready_pct <= 50;
					default: ready_pct <= 15;
				endcase
				pattern_left <= $urandom_range(20, 300);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			out_ready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	function automatic count_t random_count();
		count_t v;
		do v = count_t'({$urandom, $urandom}); while (v == '0);
		return v;
	endfunction

	// Offer one transaction and wait for it to be taken. The sender works in
	// bursts; valid stays high across back-to-back transactions of a burst.
	task automatic send_item(input in_t item);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_factorization(item);
	endtask

	// Send view_stride[0 .. rank-1], marking the innermost one with the total count.
	task automatic send_view(input int rank, input count_t total);
		in_t item;
		for (int i = 0; i < rank; i++) begin
			item.stride = view_stride[i];
			item.last_dim = (i == rank - 1);
			item.elem_total = item.last_dim ? total : random_count();
			send_item(item);
		end
		items_loaded += rank;
	endtask

	// Strides of a C-ordered view: each one a random multiple of the next inner one.
	function automatic void build_nested_view(input int rank);
		view_stride[rank - 1] = count_t'($urandom_range(1, 16));
		for (int i = rank - 2; i >= 0; i--)
			view_stride[i] = view_stride[i + 1] * count_t'($urandom_range(1, 1 << $urandom_range(0, 4)));
	endfunction

	// Stop offering and wait until every expected result has arrived.
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// A single dimension at both ends of the value range.
	task automatic test_single_dimension();
		view_stride[0] = '1;
		send_view(1, '1);
		view_stride[0] = count_t'(1);
		send_view(1, count_t'(1));
		wait_drained();
	endtask

	// Extreme strides and a full-rank C-ordered view.
	task automatic test_extreme_strides();
		view_stride[0] = '1;
		view_stride[1] = count_t'(1);
		send_view(2, '1);
		view_stride[0] = count_t'(1);
		view_stride[1] = '1;
		send_view(2, count_t'(1));
		view_stride[NUM_DIMS - 1] = count_t'(1);
		for (int i = NUM_DIMS - 2; i >= 0; i--)
			view_stride[i] = view_stride[i + 1] * count_t'(i + 2);
		send_view(NUM_DIMS, view_stride[0] * count_t'(9));
		wait_drained();
	endtask

	// More dimensions than the block holds: the innermost strides are dropped.
	task automatic test_too_many_dimensions();
		for (int i = 0; i < 10; i++)
			view_stride[i] = count_t'(1) << (2 * (9 - i));
		send_view(10, count_t'(1) << 20);
		wait_drained();
	endtask

	// Long receiver hold-off while the sender keeps offering, so the block
	// backs up and stalls its input.
	task automatic test_output_backpressure();
		hold_left = 2500;
		for (int n = 0; n < 3; n++) begin
			build_nested_view(3);
			send_view(3, random_count());
		end
		wait_drained();
	endtask

	// Well-formed C-ordered views with random extents.
	task automatic test_random_views();
		int     rank;
		count_t total;
		while (items_loaded < 320) begin
			rank = ($urandom_range(0, 3) == 0) ? $urandom_range(5, NUM_DIMS) : $urandom_range(1, 4);
			build_nested_view(rank);
			total = $urandom_range(0, 1) ? view_stride[0] * count_t'($urandom_range(1, 64))
				: random_count();
			send_view(rank, total);
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
	endtask

	// Arbitrary strides, some with a large shared factor, and some overlong views.
	task automatic test_random_strides();
		int     rank;
		count_t factor;
		bit     shared;
		while (items_loaded < LOAD_TARGET) begin
			rank = ($urandom_range(0, 6) == 0) ? $urandom_range(NUM_DIMS + 1, MAX_VIEW)
				: $urandom_range(1, NUM_DIMS);
			shared = ($urandom_range(0, 2) == 0);
			factor = count_t'($urandom_range(1, 1 << 20));
			for (int i = 0; i < rank; i++)
				view_stride[i] = shared ? factor * count_t'($urandom_range(1, 1 << 19))
					: random_count();
			send_view(rank, random_count());
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_single_dimension();
		test_extreme_strides();
		test_too_many_dimensions();
		test_output_backpressure();
		test_random_views();
		test_random_strides();
		repeat (500) @(posedge clk);
		if (mismatch_count == 0)
			$display("stride_gcd_extent_factorizer verification clean");
		else
			$display("stride_gcd_extent_factorizer verification failed");
		$finish;
	end

endmodule
